// File: design/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants for the ray/triangle intersection pipe
// Fixed-point widths for every stage, the payload word structs and the
// structs passed between the pipeline sections.
// ----------------------------------------------------------------------------
package rti_pkg;

    // Coordinate format of the input vectors.
    localparam int COORD_BITS = 21;
    localparam int FRAC_BITS  = 10;

    // Fixed widths of the port fields.
    localparam int VEC_BITS  = 63;
    localparam int EPS_BITS  = 20;
    localparam int DIST_BITS = 32;

    // Geometry widths: edge differences, pair products, cross products,
    // dot-product terms and the dot products themselves.
    localparam int DIF_BITS = COORD_BITS + 1;
    localparam int PRD_BITS = 2 * DIF_BITS;
    localparam int CRS_BITS = PRD_BITS + 1;
    localparam int TRM_BITS = DIF_BITS + CRS_BITS;
    localparam int DOT_BITS = TRM_BITS + 2;
    localparam int MAG_BITS = DOT_BITS;
    localparam int LEN_BITS = 2 * COORD_BITS + 1;

    // Distance datapath widths.
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int DIST_SHIFT  = 2 * (16 - FRAC_BITS);
    localparam int NUM_BITS    = SQ_BITS + LEN_BITS + DIST_SHIFT;
    localparam int QUO_BITS    = 64;
    localparam int ROOT_STEPS  = QUO_BITS / 2;
    localparam int REM_BITS    =
        ((NUM_BITS > SQ_BITS + QUO_BITS) ? NUM_BITS : SQ_BITS + QUO_BITS) + 1;
    localparam int EPS_SQ_BITS = 2 * EPS_BITS;
    localparam int EL_BITS     = EPS_SQ_BITS + LEN_BITS;

    // Partial-product slicing of the wide multiplies.
    localparam int SQ_CHUNK  = 18;
    localparam int SQ_STEPS  = (MAG_BITS + SQ_CHUNK - 1) / SQ_CHUNK;
    localparam int LEN_CHUNK = 11;
    localparam int LEN_STEPS = (LEN_BITS + LEN_CHUNK - 1) / LEN_CHUNK;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIF_BITS-1:0]   dif_t;
    typedef logic signed [PRD_BITS-1:0]   prd_t;
    typedef logic signed [CRS_BITS-1:0]   crs_t;
    typedef logic signed [TRM_BITS-1:0]   trm_t;
    typedef logic signed [DOT_BITS-1:0]   dot_t;
    typedef logic [MAG_BITS-1:0]          mag_t;
    typedef logic [LEN_BITS-1:0]          len_t;
    typedef logic [SQ_BITS-1:0]           sq_t;
    typedef logic [NUM_BITS-1:0]          num_t;
    typedef logic [REM_BITS-1:0]          rem_t;
    typedef logic [QUO_BITS-1:0]          quo_t;
    typedef logic [EPS_BITS-1:0]          eps_t;

    // Input word.
    typedef struct packed {
        logic [VEC_BITS-1:0] ray_origin;
        logic [VEC_BITS-1:0] ray_direction;
        logic [VEC_BITS-1:0] vertex_a;
        logic [VEC_BITS-1:0] vertex_b;
        logic [VEC_BITS-1:0] vertex_c;
    } rti_in_t;

    // Result word.
    typedef struct packed {
        logic                 hit;
        logic [DIST_BITS-1:0] distance;
    } rti_out_t;

    // Front end to multiplier section: sign-normalized determinant and
    // distance numerator, squared direction length, and the early miss flag.
    typedef struct packed {
        logic miss;
        mag_t det;
        mag_t tnum;
        len_t len2;
    } rti_geo_t;

    // Multiplier section to divider: dividend and divisor of the squared
    // distance.
    typedef struct packed {
        logic miss;
        sq_t  den;
        num_t num;
    } rti_prod_t;

    // Divider to square root: squared distance quotient and its overflow flag.
    typedef struct packed {
        logic miss;
        logic sat;
        quo_t quo;
    } rti_quo_t;

    // Signed component k of a packed vector.
    function automatic coord_t coord(input logic [VEC_BITS-1:0] vec, input int k);
        return coord_t'(vec[k*COORD_BITS +: COORD_BITS]);
    endfunction

    // Cyclic neighbors of a component index, for cross products.
    function automatic int nxt1(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    function automatic int nxt2(input int k);
        return (k == 0) ? 2 : k - 1;
    endfunction

endpackage

// File: design/ray_triangle_intersection.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersection: pipelined Moller-Trumbore ray/triangle test
// Takes one ray and triangle word per cycle unless stalled and returns the hit flag and
// the distance along the unit ray direction in unsigned Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries origin, direction and the
//   three vertices. A word is taken on a clock edge with in_valid high and
//   in_stall low. Output channel out_valid/out_stall/out_data carries hit and
//   distance; a word leaves on an edge with out_valid high and out_stall low.
//   cfg_valid/cfg_ready/cfg_data writes det_epsilon; cfg_ready is always high.
//   Write it only while no word is in flight.
// Pipeline and throughput:
//   Input to output: 7 geometry stages, 9 multiplier stages,
//   65 divider stages, 32 square root stages and the output register.
//   One word per cycle sustained while the output is not stalled; the divider
//   and root retire one bit per stage and every stage is fully pipelined.
// Reset and back pressure:
//   rst_n clears all valid bits and sets det_epsilon to 1. While the output
//   word is stalled the pipeline keeps moving as long as its last stage is
//   empty; only when a finished word waits behind the output register does
//   the whole pipeline hold and in_stall rise.
// ----------------------------------------------------------------------------
module ray_triangle_intersection (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rti_pkg::rti_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rti_pkg::rti_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  rti_pkg::eps_t     cfg_data
);
    import rti_pkg::*;

    eps_t      det_epsilon_reg;
    logic      out_valid_reg;
    rti_out_t  out_data_reg;
    logic      en;
    logic      out_load;
    logic      geo_valid;
    rti_geo_t  geo;
    logic      prod_valid;
    rti_prod_t prod;
    logic      quo_valid;
    rti_quo_t  quo;
    logic      root_valid;
    rti_out_t  root;

    // Epsilon register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_epsilon_reg <= eps_t'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            det_epsilon_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // Pipeline advance: hold only when a finished word cannot move out.
    assign out_load = !out_valid_reg || !out_stall;
    assign en       = !root_valid || out_load;
    assign in_stall = !en;

    rti_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (in_valid),
        .item       (in_data),
        .geo_valid  (geo_valid),
        .geo        (geo)
    );

    rti_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .det_epsilon (det_epsilon_reg),
        .geo_valid   (geo_valid),
        .geo         (geo),
        .prod_valid  (prod_valid),
        .prod        (prod)
    );

    rti_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prod_valid (prod_valid),
        .prod       (prod),
        .quo_valid  (quo_valid),
        .quo        (quo)
    );

    rti_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .quo_valid  (quo_valid),
        .quo        (quo),
        .root_valid (root_valid),
        .root       (root)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= root;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front: geometry front end
// Seven stages: edges, pair products, cross products, dot-product terms,
// dot products, sign normalization and the barycentric and range tests.
// ----------------------------------------------------------------------------
module rti_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              item_valid,
    input  rti_pkg::rti_in_t  item,
    output logic              geo_valid,
    output rti_pkg::rti_geo_t geo
);
    import rti_pkg::*;

    logic [6:0] valid_reg;

    coord_t dir_a_reg [3];
    dif_t   e1_a_reg [3];
    dif_t   e2_a_reg [3];
    dif_t   s_a_reg [3];

    prd_t   pa_b_reg [3];
    prd_t   pb_b_reg [3];
    prd_t   qa_b_reg [3];
    prd_t   qb_b_reg [3];
    prd_t   dd_b_reg [3];
    coord_t dir_b_reg [3];
    dif_t   e1_b_reg [3];
    dif_t   e2_b_reg [3];
    dif_t   s_b_reg [3];

    crs_t   p_c_reg [3];
    crs_t   q_c_reg [3];
    len_t   len_c_reg;
    coord_t dir_c_reg [3];
    dif_t   e1_c_reg [3];
    dif_t   e2_c_reg [3];
    dif_t   s_c_reg [3];

    trm_t   det_d_reg [3];
    trm_t   u_d_reg [3];
    trm_t   v_d_reg [3];
    trm_t   n_d_reg [3];
    len_t   len_d_reg;

    dot_t   det_e_reg;
    dot_t   u_e_reg;
    dot_t   v_e_reg;
    dot_t   n_e_reg;
    len_t   len_e_reg;

    dot_t   det_f_reg;
    dot_t   u_f_reg;
    dot_t   v_f_reg;
    dot_t   n_f_reg;
    logic   lz_f_reg;
    logic   dz_f_reg;
    len_t   len_f_reg;

    rti_geo_t geo_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[5:0], item_valid};
        end
    end

    // Stages A to C: edges, pair products, cross products and |d|^2.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dir_a_reg[k] <= coord(item.ray_direction, k);
                e1_a_reg[k]  <= dif_t'(coord(item.vertex_b, k))
                                - dif_t'(coord(item.vertex_a, k));
                e2_a_reg[k]  <= dif_t'(coord(item.vertex_c, k))
                                - dif_t'(coord(item.vertex_a, k));
                s_a_reg[k]   <= dif_t'(coord(item.ray_origin, k))
                                - dif_t'(coord(item.vertex_a, k));

                pa_b_reg[k]  <= prd_t'(dir_a_reg[nxt1(k)]) * prd_t'(e2_a_reg[nxt2(k)]);
                pb_b_reg[k]  <= prd_t'(dir_a_reg[nxt2(k)]) * prd_t'(e2_a_reg[nxt1(k)]);
                qa_b_reg[k]  <= prd_t'(s_a_reg[nxt1(k)]) * prd_t'(e1_a_reg[nxt2(k)]);
                qb_b_reg[k]  <= prd_t'(s_a_reg[nxt2(k)]) * prd_t'(e1_a_reg[nxt1(k)]);
                dd_b_reg[k]  <= prd_t'(dir_a_reg[k]) * prd_t'(dir_a_reg[k]);
                dir_b_reg[k] <= dir_a_reg[k];
                e1_b_reg[k]  <= e1_a_reg[k];
                e2_b_reg[k]  <= e2_a_reg[k];
                s_b_reg[k]   <= s_a_reg[k];

                p_c_reg[k]   <= crs_t'(pa_b_reg[k]) - crs_t'(pb_b_reg[k]);
                q_c_reg[k]   <= crs_t'(qa_b_reg[k]) - crs_t'(qb_b_reg[k]);
                dir_c_reg[k] <= dir_b_reg[k];
                e1_c_reg[k]  <= e1_b_reg[k];
                e2_c_reg[k]  <= e2_b_reg[k];
                s_c_reg[k]   <= s_b_reg[k];
            end
            len_c_reg <= len_t'(dd_b_reg[0] + dd_b_reg[1] + dd_b_reg[2]);
        end
    end

    // Stages D and E: dot products det = e1.p, U = s.p, V = d.q, N = e2.q.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                det_d_reg[k] <= trm_t'(e1_c_reg[k]) * trm_t'(p_c_reg[k]);
                u_d_reg[k]   <= trm_t'(s_c_reg[k]) * trm_t'(p_c_reg[k]);
                v_d_reg[k]   <= trm_t'(dir_c_reg[k]) * trm_t'(q_c_reg[k]);
                n_d_reg[k]   <= trm_t'(e2_c_reg[k]) * trm_t'(q_c_reg[k]);
            end
            len_d_reg <= len_c_reg;

            det_e_reg <= dot_t'(det_d_reg[0]) + dot_t'(det_d_reg[1]) + dot_t'(det_d_reg[2]);
            u_e_reg   <= dot_t'(u_d_reg[0]) + dot_t'(u_d_reg[1]) + dot_t'(u_d_reg[2]);
            v_e_reg   <= dot_t'(v_d_reg[0]) + dot_t'(v_d_reg[1]) + dot_t'(v_d_reg[2]);
            n_e_reg   <= dot_t'(n_d_reg[0]) + dot_t'(n_d_reg[1]) + dot_t'(n_d_reg[2]);
            len_e_reg <= len_d_reg;
        end
    end

    // Stage F: flip all signs so that the determinant is not negative.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_f_reg <= det_e_reg[DOT_BITS-1] ? -det_e_reg : det_e_reg;
            u_f_reg   <= det_e_reg[DOT_BITS-1] ? -u_e_reg : u_e_reg;
            v_f_reg   <= det_e_reg[DOT_BITS-1] ? -v_e_reg : v_e_reg;
            n_f_reg   <= det_e_reg[DOT_BITS-1] ? -n_e_reg : n_e_reg;
            lz_f_reg  <= (len_e_reg == '0);
            dz_f_reg  <= (det_e_reg == '0);
            len_f_reg <= len_e_reg;
        end
    end

    // Stage G: miss on zero direction, zero determinant, u or v out of range,
    // or a hit at or behind the origin.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg.miss <= lz_f_reg | dz_f_reg
                            | u_f_reg[DOT_BITS-1] | (u_f_reg > det_f_reg)
                            | v_f_reg[DOT_BITS-1] | ((u_f_reg + v_f_reg) > det_f_reg)
                            | n_f_reg[DOT_BITS-1] | (n_f_reg == '0);
            geo_reg.det  <= mag_t'(det_f_reg);
            geo_reg.tnum <= mag_t'(n_f_reg);
            geo_reg.len2 <= len_f_reg;
        end
    end

    assign geo_valid = valid_reg[6];
    assign geo       = geo_reg;

endmodule

// File: design/rti_mult.sv
// ----------------------------------------------------------------------------
// rti_mult: wide multiplier section
// Forms det^2 and N^2 one slice per stage, then N^2*|d|^2 and eps^2*|d|^2
// one slice per stage, and finally applies the near-parallel test and scales the dividend.
// ----------------------------------------------------------------------------
module rti_mult (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  rti_pkg::eps_t      det_epsilon,
    input  logic               geo_valid,
    input  rti_pkg::rti_geo_t  geo,
    output logic               prod_valid,
    output rti_pkg::rti_prod_t prod
);
    import rti_pkg::*;

    localparam int CMP_BITS = (SQ_BITS > EL_BITS) ? SQ_BITS : EL_BITS;

    typedef logic [EPS_SQ_BITS-1:0]          esq_t;
    typedef logic [SQ_BITS+LEN_BITS-1:0]     nl_t;
    typedef logic [EL_BITS-1:0]              el_t;
    typedef logic [MAG_BITS+SQ_CHUNK-1:0]    sqpp_t;
    typedef logic [SQ_BITS+LEN_CHUNK-1:0]    nlpp_t;
    typedef logic [EPS_SQ_BITS+LEN_CHUNK-1:0] elpp_t;
    typedef logic [SQ_STEPS*SQ_CHUNK-1:0]    sqpad_t;
    typedef logic [LEN_STEPS*LEN_CHUNK-1:0]  lnpad_t;
    typedef logic [CMP_BITS-1:0]             cmp_t;

    typedef struct packed {
        logic miss;
        mag_t det;
        mag_t tnum;
        len_t len2;
        esq_t eps_sq;
        sq_t  den;
        sq_t  nsq;
    } sq_stage_t;

    typedef struct packed {
        logic miss;
        sq_t  den;
        sq_t  nsq;
        len_t len2;
        esq_t eps_sq;
        nl_t  num;
        el_t  el;
    } ln_stage_t;

    sq_stage_t sq_reg [SQ_STEPS];
    logic      sq_valid_reg [SQ_STEPS];
    ln_stage_t ln_reg [LEN_STEPS];
    logic      ln_valid_reg [LEN_STEPS];
    rti_prod_t prod_reg;
    logic      prod_valid_reg;

    // Squaring stages: one slice of det and N per stage.
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        sq_stage_t src;
        sq_stage_t nxt;
        logic      src_valid;
        sqpad_t    det_pad;
        sqpad_t    tnum_pad;
        sqpp_t     det_pp;
        sqpp_t     tnum_pp;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                src_valid  = geo_valid;
                src.miss   = geo.miss;
                src.det    = geo.det;
                src.tnum   = geo.tnum;
                src.len2   = geo.len2;
                src.eps_sq = esq_t'(det_epsilon) * esq_t'(det_epsilon);
                src.den    = '0;
                src.nsq    = '0;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                src_valid = sq_valid_reg[k-1];
                src       = sq_reg[k-1];
            end
        end

        // Add this slice's partial products to the running squares.
        always_comb
        begin
            det_pad  = sqpad_t'(src.det);
            tnum_pad = sqpad_t'(src.tnum);
            det_pp   = sqpp_t'(src.det) * sqpp_t'(det_pad[k*SQ_CHUNK +: SQ_CHUNK]);
            tnum_pp  = sqpp_t'(src.tnum) * sqpp_t'(tnum_pad[k*SQ_CHUNK +: SQ_CHUNK]);
            nxt      = src;
            nxt.den  = src.den + (sq_t'(det_pp) << (k * SQ_CHUNK));
            nxt.nsq  = src.nsq + (sq_t'(tnum_pp) << (k * SQ_CHUNK));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k] <= nxt;
            end
        end
    end

    // Length stages: one slice of |d|^2 per stage against N^2 and eps^2.
    for (genvar k = 0; k < LEN_STEPS; k++)
    begin : g_ln
        ln_stage_t src;
        ln_stage_t nxt;
        logic      src_valid;
        lnpad_t    len_pad;
        nlpp_t     num_pp;
        elpp_t     el_pp;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                src_valid  = sq_valid_reg[SQ_STEPS-1];
                src.miss   = sq_reg[SQ_STEPS-1].miss;
                src.den    = sq_reg[SQ_STEPS-1].den;
                src.nsq    = sq_reg[SQ_STEPS-1].nsq;
                src.len2   = sq_reg[SQ_STEPS-1].len2;
                src.eps_sq = sq_reg[SQ_STEPS-1].eps_sq;
                src.num    = '0;
                src.el     = '0;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                src_valid = ln_valid_reg[k-1];
                src       = ln_reg[k-1];
            end
        end

        // Add this slice's partial products to the running products.
        always_comb
        begin
            len_pad = lnpad_t'(src.len2);
            num_pp  = nlpp_t'(src.nsq) * nlpp_t'(len_pad[k*LEN_CHUNK +: LEN_CHUNK]);
            el_pp   = elpp_t'(src.eps_sq) * elpp_t'(len_pad[k*LEN_CHUNK +: LEN_CHUNK]);
            nxt     = src;
            nxt.num = src.num + (nl_t'(num_pp) << (k * LEN_CHUNK));
            nxt.el  = src.el + (el_t'(el_pp) << (k * LEN_CHUNK));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ln_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                ln_valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ln_reg[k] <= nxt;
            end
        end
    end

    // Near-parallel test det^2 < eps^2 * |d|^2, and scaling of the dividend.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= ln_valid_reg[LEN_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg.miss <= ln_reg[LEN_STEPS-1].miss
                             | (cmp_t'(ln_reg[LEN_STEPS-1].den)
                                < cmp_t'(ln_reg[LEN_STEPS-1].el));
            prod_reg.den  <= ln_reg[LEN_STEPS-1].den;
            prod_reg.num  <= num_t'(ln_reg[LEN_STEPS-1].num) << DIST_SHIFT;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

// File: design/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div: pipelined restoring divider
// One overflow check stage, then one quotient bit per stage, most
// significant first, for the squared distance N^2*|d|^2 / det^2.
// ----------------------------------------------------------------------------
module rti_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               prod_valid,
    input  rti_pkg::rti_prod_t prod,
    output logic               quo_valid,
    output rti_pkg::rti_quo_t  quo
);
    import rti_pkg::*;

    typedef struct packed {
        logic miss;
        logic sat;
        rem_t rem;
        sq_t  den;
        quo_t quo;
    } dv_stage_t;

    dv_stage_t dv_reg [QUO_BITS+1];
    logic      dv_valid_reg [QUO_BITS+1];

    for (genvar k = 0; k <= QUO_BITS; k++)
    begin : g_dv
        dv_stage_t nxt;
        logic      nxt_valid;

        if (k == 0)
        begin : g_first
            // A quotient of 2^64 or more saturates the distance.
            always_comb
            begin
                nxt_valid = prod_valid;
                nxt.miss  = prod.miss;
                nxt.rem   = rem_t'(prod.num);
                nxt.den   = prod.den;
                nxt.quo   = '0;
                nxt.sat   = rem_t'(prod.num) >= (rem_t'(prod.den) << QUO_BITS);
            end
        end
        else
        begin : g_bit
            rem_t trial;
            logic ge;

            // Subtract the shifted divisor where it fits.
            always_comb
            begin
                nxt_valid = dv_valid_reg[k-1];
                nxt       = dv_reg[k-1];
                trial     = rem_t'(dv_reg[k-1].den) << (QUO_BITS - k);
                ge        = dv_reg[k-1].rem >= trial;
                if (ge)
                begin
                    nxt.rem               = dv_reg[k-1].rem - trial;
                    nxt.quo[QUO_BITS - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[k] <= nxt_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[k] <= nxt;
            end
        end
    end

    assign quo_valid = dv_valid_reg[QUO_BITS];
    assign quo.miss  = dv_reg[QUO_BITS].miss;
    assign quo.sat   = dv_reg[QUO_BITS].sat;
    assign quo.quo   = dv_reg[QUO_BITS].quo;

endmodule

// File: design/rti_sqrt.sv
// ----------------------------------------------------------------------------
// rti_sqrt: pipelined integer square root
// Digit-by-digit root of the 64-bit quotient, one result bit per stage,
// and formatting of the result word from the last stage.
// ----------------------------------------------------------------------------
module rti_sqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              quo_valid,
    input  rti_pkg::rti_quo_t quo,
    output logic              root_valid,
    output rti_pkg::rti_out_t root
);
    import rti_pkg::*;

    typedef struct packed {
        logic miss;
        logic sat;
        quo_t x;
        quo_t res;
    } rt_stage_t;

    rt_stage_t rt_reg [ROOT_STEPS];
    logic      rt_valid_reg [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_rt
        rt_stage_t src;
        rt_stage_t nxt;
        logic      src_valid;
        quo_t      bitc;
        quo_t      trial;
        logic      ge;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                src_valid = quo_valid;
                src.miss  = quo.miss;
                src.sat   = quo.sat;
                src.x     = quo.quo;
                src.res   = '0;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                src_valid = rt_valid_reg[k-1];
                src       = rt_reg[k-1];
            end
        end

        // One root bit: take res + bit off the remainder where it fits.
        always_comb
        begin
            bitc  = quo_t'(1) << (QUO_BITS - 2 - 2 * k);
            trial = src.res + bitc;
            ge    = src.x >= trial;
            nxt   = src;
            if (ge)
            begin
                nxt.x   = src.x - trial;
                nxt.res = (src.res >> 1) + bitc;
            end
            else
            begin
                nxt.res = src.res >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                rt_valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_reg[k] <= nxt;
            end
        end
    end

    // A miss reports zero distance; an overflowed quotient saturates.
    always_comb
    begin
        root.hit = !rt_reg[ROOT_STEPS-1].miss;
        if (rt_reg[ROOT_STEPS-1].miss)
        begin
            root.distance = '0;
        end
        else if (rt_reg[ROOT_STEPS-1].sat)
        begin
            root.distance = '1;
        end
        else
        begin
            root.distance = rt_reg[ROOT_STEPS-1].res[DIST_BITS-1:0];
        end
    end

    assign root_valid = rt_valid_reg[ROOT_STEPS-1];

endmodule
